FILE: src/rpb_pkg.sv
// Package for the random pop bag: sizes, request and response beat types,
// request and status codes, and the control bundle shared by the cell row.
// No dependencies.
package rpb_pkg;

  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;

  // Field widths fixed by the interface.
  localparam int KIND_W  = 2;
  localparam int ITEM_W  = 32;
  localparam int IDX_W   = 8;
  localparam int RAND_W  = 16;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 7;

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = IDX_W + 1;
  localparam int PROD_W  = RAND_W + CNT_W;

  // The pop result is gathered through a registered OR tree of this group size.
  localparam int GRP_SIZE = 8;
  localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  typedef enum logic [KIND_W-1:0] {
    REQ_APPEND   = 2'd0,
    REQ_POP_AT   = 2'd1,
    REQ_POP_RAND = 2'd2,
    REQ_NONE     = 2'd3
  } req_kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_INDEX,
    FSM_GATHER,
    FSM_APPLY
  } fsm_e;

  typedef struct packed {
    logic [KIND_W-1:0] req_type;
    logic [ITEM_W-1:0] item_value;
    logic [IDX_W-1:0]  pop_index;
    logic [RAND_W-1:0] rand_word;
  } req_t;

  typedef struct packed {
    logic [ITEM_W-1:0] popped_value;
    logic [STAT_W-1:0] status;
    logic [ECNT_W-1:0] entry_count;
  } rsp_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic                 load;
    logic                 shift;
    logic [IDX_W-1:0]     pos;
    logic [IDX_W-1:0]     tail;
    logic [WORD_BITS-1:0] word;
  } cell_ctrl_t;

endpackage

FILE: src/rpb_cell.sv
// One storage cell of the bag: holds one word, loads on append at the tail,
// takes its upper neighbour's word when a pop closes the gap. Uses rpb_pkg.
module rpb_cell import rpb_pkg::*; (
  input  logic                 clk_i,
  input  logic [IDX_W-1:0]     cell_idx_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic [WORD_BITS-1:0] next_word_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic [WORD_BITS-1:0] sel_word_o
);

  logic [WORD_BITS-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.load && (cell_idx_i == ctrl_i.tail)) begin
      word_d = ctrl_i.word;
    end else if (ctrl_i.shift && (cell_idx_i >= ctrl_i.pos)) begin
      word_d = next_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o     = word_q;
  assign sel_word_o = (cell_idx_i == ctrl_i.pos) ? word_q : '0;

endmodule

FILE: src/rpb_gather.sv
// Registered OR tree that collects the one selected word out of the cell row.
// Uses rpb_pkg.
module rpb_gather import rpb_pkg::*; (
  input  logic                 clk_i,
  input  logic [WORD_BITS-1:0] sel_words_i [CAPACITY],
  output logic [WORD_BITS-1:0] word_o
);

  logic [WORD_BITS-1:0] grp_q [NUM_GRP];
  logic [WORD_BITS-1:0] grp_d [NUM_GRP];

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < CAPACITY) begin
          grp_d[g] = grp_d[g] | sel_words_i[g * GRP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    word_o = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      word_o = word_o | grp_q[g];
    end
  end

endmodule

FILE: src/random_pop_bag.sv
// Random pop bag: an ordered store of up to CAPACITY words held in a row of
// cells. Each request beat (append, pop at an index, pop at a random index)
// gives exactly one response beat carrying the removed word, a status code and
// the entry count after the request. After a request beat is accepted the block
// picks the index with the random multiply, then selects the cell with the first
// OR level, then does the final OR and the cell update and registers the
// response beat; a new request is taken only after that last step, so one
// request is in work at a time. A response that is not taken holds the last step
// until the output register is free. The next request is accepted while a
// response still waits. Depends on rpb_pkg, rpb_cell and rpb_gather.
module random_pop_bag import rpb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  logic req_valid_i,
  output logic req_ready_o,
  output rsp_t rsp_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i
);

  fsm_e                 state_q, state_d;
  req_t                 req_q;
  logic [IDX_W-1:0]     pos_q, pos_d;
  status_e              stat_q, stat_d;
  logic [CNT_W-1:0]     count_q, count_d;
  rsp_t                 rsp_q, rsp_d;
  logic                 rsp_valid_q, rsp_valid_d;
  logic                 fire;
  logic [PROD_W-1:0]    prod;
  logic [CMP_W-1:0]     pos_ext, cnt_ext;
  logic [WORD_BITS-1:0] popped;
  logic [WORD_BITS-1:0] words     [CAPACITY];
  logic [WORD_BITS-1:0] sel_words [CAPACITY];
  cell_ctrl_t           ctrl;

  assign prod    = PROD_W'(req_q.rand_word) * PROD_W'(count_q);
  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(count_q);

  // Outcome of the request, from the latched index and the current count.
  always_comb begin
    stat_d = ST_OK;
    case (req_kind_e'(req_q.req_type))
      REQ_APPEND: begin
        if (cnt_ext >= CMP_W'(CAPACITY)) begin
          stat_d = ST_FULL;
        end
      end
      REQ_POP_AT, REQ_POP_RAND: begin
        if (count_q == '0) begin
          stat_d = (pos_q != '0) ? ST_BOUNDS : ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          stat_d = ST_BOUNDS;
        end
      end
      default: stat_d = ST_OK;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    count_d     = count_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    req_ready_o = 1'b0;
    fire        = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          state_d = FSM_INDEX;
        end
      end
      FSM_INDEX: begin
        if (req_kind_e'(req_q.req_type) == REQ_POP_RAND) begin
          pos_d = IDX_W'(prod[PROD_W-1:RAND_W]);
        end else begin
          pos_d = req_q.pop_index;
        end
        state_d = FSM_GATHER;
      end
      FSM_GATHER: begin
        state_d = FSM_APPLY;
      end
      FSM_APPLY: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          fire        = 1'b1;
          rsp_valid_d = 1'b1;
          rsp_d.status       = stat_q;
          rsp_d.popped_value = '0;
          count_d            = count_q;
          if (stat_q == ST_OK) begin
            case (req_kind_e'(req_q.req_type))
              REQ_APPEND: count_d = count_q + 1'b1;
              REQ_POP_AT, REQ_POP_RAND: begin
                count_d            = count_q - 1'b1;
                rsp_d.popped_value = ITEM_W'(popped);
              end
              default: count_d = count_q;
            endcase
          end
          rsp_d.entry_count = ECNT_W'(count_d);
          state_d           = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    pos_q  <= pos_d;
    stat_q <= stat_d;
    rsp_q  <= rsp_d;
  end

  // The cells change only when the response is loaded, and only on success.
  always_comb begin
    ctrl.load  = fire && (stat_q == ST_OK)
                 && (req_kind_e'(req_q.req_type) == REQ_APPEND);
    ctrl.shift = fire && (stat_q == ST_OK)
                 && ((req_kind_e'(req_q.req_type) == REQ_POP_AT)
                     || (req_kind_e'(req_q.req_type) == REQ_POP_RAND));
    ctrl.pos   = pos_q;
    ctrl.tail  = IDX_W'(count_q);
    ctrl.word  = WORD_BITS'(req_q.item_value);
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [WORD_BITS-1:0] next_word;
    if (k == CAPACITY - 1) begin : g_last
      assign next_word = '0;
    end else begin : g_inner
      assign next_word = words[k+1];
    end

    rpb_cell u_cell (
      .clk_i       (clk_i),
      .cell_idx_i  (IDX_W'(k)),
      .ctrl_i      (ctrl),
      .next_word_i (next_word),
      .word_o      (words[k]),
      .sel_word_o  (sel_words[k])
    );
  end

  rpb_gather u_gather (
    .clk_i       (clk_i),
    .sel_words_i (sel_words),
    .word_o      (popped)
  );

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

FILE: src/rpb_checker.sv
// Port-level checks for the random pop bag, bound to random_pop_bag.
// Uses rpb_pkg.
module rpb_checker import rpb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input req_t req_i,
  input logic req_valid_i,
  input logic req_ready_o,
  input rsp_t rsp_o,
  input logic rsp_valid_o,
  input logic rsp_ready_i
);

  // A held response beat must not change under back-pressure.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response beat changed while stalled");

  // One request at a time: the input closes for the cycle after a beat.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request accepted back to back");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.entry_count <= ECNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status != ST_OK) |-> rsp_o.popped_value == '0)
    else $error("failed request returned a word");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status == ST_FULL)
      |-> rsp_o.entry_count == ECNT_W'(CAPACITY))
    else $error("full status with room left");

endmodule

bind random_pop_bag rpb_checker u_rpb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_i       (req_i),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .rsp_o       (rsp_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i)
);
